// File: rtl/core/bspq_pkg.sv
// Shared types and constants for the bounded stable priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bspq_pkg;

	localparam int PRIO_W      = 32;
	localparam int TAG_PORT_W  = 32;
	localparam int CNT_PORT_W  = 5;
	localparam int LIMIT_W     = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam logic CMD_ADD      = 1'b0;
	localparam logic CMD_COMPLETE = 1'b1;

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_RESP = 1'b1
	} bspq_state_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic apply;
	} bspq_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic empty;
		logic full;
	} bspq_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bspq_ctrl.sv
// Controller state machine of the priority queue: input and output handshakes.
// Depends on bspq_pkg for the state and command types.
`default_nettype none

module bspq_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	input  bspq_pkg::bspq_stat_t stat,
	output bspq_pkg::bspq_cmd_t  cmd
);
	import bspq_pkg::*;

	bspq_state_t state_q;
	bspq_state_t state_d;
	logic        stat_seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// A refused add or complete is still applied, because it returns a result
	// word as well; the datapath gates the slot update with full and empty.
	assign stat_seen = stat.full | stat.empty;

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd.apply = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cmd.apply = in_valid | (in_valid & stat_seen);
			end
			S_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/bspq_dp.sv
// Datapath of the priority queue: sorted slot registers, count, limit register.
// Depends on bspq_pkg for widths, command codes and the command/status types.
`default_nettype none

module bspq_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  bspq_pkg::bspq_cmd_t                 cmd,
	output bspq_pkg::bspq_stat_t                stat,
	input  wire                                 cfg_we,
	input  wire  [bspq_pkg::LIMIT_W-1:0]        cfg_wdata,
	input  wire                                 command,
	input  wire  signed [bspq_pkg::PRIO_W-1:0]  priority_req,
	input  wire  [bspq_pkg::TAG_PORT_W-1:0]     task_tag,
	output logic                                ok,
	output logic [bspq_pkg::CNT_PORT_W-1:0]     entry_count,
	output logic                                is_empty_flag,
	output logic signed [bspq_pkg::PRIO_W-1:0]  head_priority,
	output logic [bspq_pkg::TAG_PORT_W-1:0]     head_tag
);
	import bspq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

	logic signed [PRIO_W-1:0]   slot_prio_q [QUEUE_DEPTH];
	logic        [TAG_BITS-1:0] slot_tag_q  [QUEUE_DEPTH];
	logic        [CW-1:0]       count_q;
	logic        [LIMIT_W-1:0]  max_q;
	logic                       ok_q;

	logic [QUEUE_DEPTH-1:0] ge;
	logic [TAG_BITS-1:0]    tag_in;
	logic [LW-1:0]          limit;
	logic [LW-1:0]          count_l;
	logic                   can_add;
	logic                   can_remove;
	logic                   do_add;
	logic                   do_remove;

	assign tag_in  = TAG_BITS'(task_tag);
	assign count_l = LW'(count_q);
	assign limit   = (LW'(max_q) > DEPTH_L) ? DEPTH_L : LW'(max_q);

	assign can_add    = count_l < limit;
	assign can_remove = count_q != '0;
	assign do_add     = cmd.apply && (command == CMD_ADD) && can_add;
	assign do_remove  = cmd.apply && (command == CMD_COMPLETE) && can_remove;

	assign stat.full  = !can_add;
	assign stat.empty = !can_remove;

	// A valid slot whose priority is at least the new one stays in place, so
	// the new word lands behind all equal priorities. The mask is a prefix.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ge[i] = (CW'(i) < count_q) && (slot_prio_q[i] >= priority_req);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (do_add && !ge[i]) begin
				if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
					slot_prio_q[i] <= priority_req;
					slot_tag_q[i]  <= tag_in;
				end else begin
					slot_prio_q[i] <= slot_prio_q[(i == 0) ? 0 : i - 1];
					slot_tag_q[i]  <= slot_tag_q[(i == 0) ? 0 : i - 1];
				end
			end else if (do_remove && i < QUEUE_DEPTH - 1) begin
				slot_prio_q[i] <= slot_prio_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
				slot_tag_q[i]  <= slot_tag_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= LIMIT_RESET;
			ok_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (cmd.apply) begin
				ok_q <= do_add | do_remove;
			end
			if (do_add) begin
				count_q <= count_q + CW'(1);
			end else if (do_remove) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign ok            = ok_q;
	assign entry_count   = CNT_PORT_W'(count_q);
	assign is_empty_flag = (count_q == '0);
	assign head_priority = (count_q == '0) ? '0 : slot_prio_q[0];
	assign head_tag      = (count_q == '0) ? '0 : TAG_PORT_W'(slot_tag_q[0]);

endmodule

`default_nettype wire

// File: rtl/core/bounded_stable_priority_queue.sv
// Top level of the bounded stable priority queue.
// Instantiates bspq_ctrl and bspq_dp; types come from bspq_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall) carries one word per item:
//   command (add or complete), priority_req and task_tag. The output channel
//   (out_valid, out_stall) returns one word per item: ok, entry_count,
//   is_empty_flag and the head entry as it stands after the item.
//   The queue is a row of slot registers kept sorted by descending signed
//   priority; every slot compares against the new priority in parallel and
//   shifts by one place, so an add or complete finishes in the accept cycle.
//   The result word appears on the next cycle and stays until it is taken.
//   An item is accepted and applied to the slots in S_IDLE; its result is
//   handed over in S_RESP, and the controller takes the next word once the
//   result has left. A stall on the output holds the result and keeps
//   in_stall high.
//   The user must write max_entries via cfg_we and cfg_wdata only while the
//   block is idle; the block does not enforce it. Values above QUEUE_DEPTH
//   act as QUEUE_DEPTH. Reset empties the queue and sets the limit to 16;
//   slot contents are not cleared, as only occupied slots are ever read.
`default_nettype none

module bounded_stable_priority_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [bspq_pkg::LIMIT_W-1:0]        cfg_wdata,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire                                 command,
	input  wire  signed [bspq_pkg::PRIO_W-1:0]  priority_req,
	input  wire  [bspq_pkg::TAG_PORT_W-1:0]     task_tag,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic                                ok,
	output logic [bspq_pkg::CNT_PORT_W-1:0]     entry_count,
	output logic                                is_empty_flag,
	output logic signed [bspq_pkg::PRIO_W-1:0]  head_priority,
	output logic [bspq_pkg::TAG_PORT_W-1:0]     head_tag
);
	import bspq_pkg::*;

	bspq_cmd_t  cmd;
	bspq_stat_t stat;

	bspq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bspq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.command       (command),
		.priority_req  (priority_req),
		.task_tag      (task_tag),
		.ok            (ok),
		.entry_count   (entry_count),
		.is_empty_flag (is_empty_flag),
		.head_priority (head_priority),
		.head_tag      (head_tag)
	);

endmodule

`default_nettype wire
